### rtl/eci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eci_pkg: shared types and constants
// field widths, register indexes, operation codes and sequencer states of the
// calibration interpolator
// ----------------------------------------------------------------------------
package eci_pkg;

  localparam int RAW_W      = 12;
  localparam int SPAN_W     = RAW_W + 1;
  localparam int ANGLE_W    = 17;
  localparam int EIU_W      = 7;
  localparam int SI_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ENTRY_W    = 6;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = {ANGLE_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 1'b1;

  localparam logic [EIU_W-1:0] EIU_RESET = 7'd40;
  localparam logic [SI_W-1:0]  SI_RESET  = 13'd144;

  // operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // plain conversion: counts * 360 / 4096
  localparam int DEG_PER_TURN = 360;
  localparam int RAW_SHIFT    = 12;
  localparam int FB_PROD_W    = 21;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NUM,
    ST_PROD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FALLBACK,
    ST_RESULT
  } eci_state_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic [ANGLE_W-1:0] quo;
  } div_result_t;

endpackage
`default_nettype wire

### rtl/encoder_calibration_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_calibration_interpolator: calibration table linearizer
// maps a raw 12-bit magnet angle to degrees through a table of raw counts
// ----------------------------------------------------------------------------
// request channel (req_valid / req_stall): a load request writes raw_angle
//   into entry entry_index, no response; a convert request gives one response
//   (angle, interpolated, span_error) on rsp_valid / rsp_stall
// configuration (cfg_we / cfg_index / cfg_data) is to be written while idle;
//   the block itself does not enforce this
// sequence: a load writes the table and stays idle; a convert reads one table
//   entry per cycle behind the registered ram read, then forms its products
//   and runs the serial divider (skipped on zero span or clamp, cut short on
//   saturation); with no hit, or under two entries, the plain fallback is used
// reset: clears the sequencer and response register and restores 40 entries
//   and interval 144; the table is not cleared and must be loaded before use
// stalls: a stalled response holds; a finished convert waits in its result
//   state and no request is taken; one response may wait while the next
//   request is already being worked on
// ----------------------------------------------------------------------------
module encoder_calibration_interpolator #(
  parameter int MAX_ENTRIES   = 64,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [eci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [eci_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic                            operation,
  input  wire logic [eci_pkg::ENTRY_W-1:0]     entry_index,
  input  wire logic [eci_pkg::RAW_W-1:0]       raw_angle,
  // response channel
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic      [eci_pkg::ANGLE_W-1:0]     angle,
  output logic                                 interpolated,
  output logic                                 span_error
);

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NUM_W   = IDX_W + eci_pkg::SPAN_W;     // signed numerator
  localparam int MAG_W   = NUM_W - 1;                   // its magnitude
  localparam int PROD_W  = MAG_W + eci_pkg::SI_W;
  localparam int DVD_W   = PROD_W + FRACTION_BITS - 4;  // 1/16 degree folded in
  localparam int FB_W    = eci_pkg::FB_PROD_W + FRACTION_BITS;
  localparam int FBQ_W   = FB_W - eci_pkg::RAW_SHIFT;
  localparam int SW      = eci_pkg::SPAN_W;

  // configuration registers
  logic [eci_pkg::EIU_W-1:0] entries_in_use;
  logic [eci_pkg::SI_W-1:0]  sample_interval;

  // sequencer
  eci_pkg::eci_state_t state, state_next;

  // item registers
  logic [eci_pkg::RAW_W-1:0] raw;
  logic [IDX_W-1:0]          n_last;
  logic [IDX_W-1:0]          rd_ptr;
  logic [IDX_W-1:0]          data_idx;
  logic                      data_vld;
  logic [IDX_W-1:0]          k;
  logic [eci_pkg::RAW_W-1:0] lo;
  logic [eci_pkg::RAW_W-1:0] hi;
  logic signed [NUM_W-1:0]   num;
  logic signed [SW-1:0]      span;
  logic [DVD_W-1:0]          dividend;
  logic [eci_pkg::RAW_W-1:0] divisor;

  // result registers
  logic [eci_pkg::ANGLE_W-1:0] res_angle;
  logic                        res_interp;
  logic                        res_err;

  // table ram
  logic                      tbl_we;
  logic [IDX_W-1:0]          tbl_waddr;
  logic [eci_pkg::RAW_W-1:0] tbl_rdata;

  eci_pkg::div_result_t div_res;
  logic                 div_start;

  logic req_take;
  logic load_take;
  logic conv_take;
  logic few_entries;
  logic [IDX_W-1:0] n_last_next;
  logic hit;
  logic scan_end;
  logic rsp_load;
  logic rsp_take;

  // span and numerator
  logic signed [SW-1:0]    d1;
  logic signed [SW-1:0]    d2;
  logic signed [NUM_W-1:0] num_next;

  // sign handling and scaled product
  logic             zero_span;
  logic             num_neg;
  logic             clamp;
  logic [NUM_W-1:0] num_abs;
  logic [SW-1:0]    span_abs;
  logic [PROD_W-1:0] product;

  // plain conversion
  logic [FB_W-1:0]  fb_full;
  logic [FBQ_W-1:0] fb;
  logic             fb_sat;

  assign req_stall = (state != eci_pkg::ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign load_take = req_take && (operation == eci_pkg::OP_LOAD);
  assign conv_take = req_take && (operation == eci_pkg::OP_CONVERT);

  // ------------------------------------------------------------------
  // configuration
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use  <= eci_pkg::EIU_RESET;
      sample_interval <= eci_pkg::SI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        eci_pkg::CFG_ENTRIES_IN_USE:  entries_in_use  <= cfg_data[eci_pkg::EIU_W-1:0];
        eci_pkg::CFG_SAMPLE_INTERVAL: sample_interval <= cfg_data[eci_pkg::SI_W-1:0];
        default: ;
      endcase
    end
  end

  // entries beyond the table act as a full table; fewer than two means no search
  assign few_entries = (entries_in_use < eci_pkg::EIU_W'(2));
  assign n_last_next = (32'(entries_in_use) > MAX_ENTRIES) ? IDX_W'(MAX_ENTRIES - 1)
                                                           : IDX_W'(entries_in_use - 1'b1);

  // ------------------------------------------------------------------
  // table, written by load requests, read once per cycle by the scan
  // ------------------------------------------------------------------
  assign tbl_we    = load_take && (32'(entry_index) < MAX_ENTRIES);
  assign tbl_waddr = IDX_W'(entry_index);

  eci_ram #(
    .WIDTH (eci_pkg::RAW_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (raw_angle),
    .raddr (rd_ptr),
    .rdata (tbl_rdata)
  );

  // first entry above the reading; entry zero only seeds the lower bound
  assign hit      = data_vld && (data_idx != '0) && (tbl_rdata > raw);
  assign scan_end = data_vld && (data_idx == n_last);

  // ------------------------------------------------------------------
  // arithmetic per stage
  // ------------------------------------------------------------------
  assign d1       = $signed({1'b0, raw}) - $signed({1'b0, lo});
  assign d2       = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign num_next = $signed(NUM_W'(k - 1'b1)) * NUM_W'(d2) + NUM_W'(d1);

  assign zero_span = (span == '0);
  assign num_neg   = num[NUM_W-1];
  assign clamp     = (num != '0) && (num_neg != span[SW-1]);
  assign num_abs   = num_neg ? NUM_W'(-num) : NUM_W'(num);
  assign span_abs  = span[SW-1] ? SW'(-span) : SW'(span);
  assign product   = PROD_W'(num_abs[MAG_W-1:0]) * PROD_W'(sample_interval);

  assign fb_full = (FB_W'(raw) * FB_W'(eci_pkg::DEG_PER_TURN)) << FRACTION_BITS;
  assign fb      = fb_full[FB_W-1:eci_pkg::RAW_SHIFT];
  assign fb_sat  = (32'(fb) > 32'(eci_pkg::ANGLE_MAX));

  assign div_start = (state == eci_pkg::ST_DIV_GO);

  eci_divider #(
    .DVD_W (DVD_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .result   (div_res)
  );

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eci_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rsp_load   = 1'b0;
    case (state)
      eci_pkg::ST_IDLE: begin
        if (conv_take) begin
          state_next = few_entries ? eci_pkg::ST_FALLBACK : eci_pkg::ST_SCAN;
        end
      end
      eci_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = eci_pkg::ST_NUM;
        end else if (scan_end) begin
          state_next = eci_pkg::ST_FALLBACK;
        end
      end
      eci_pkg::ST_NUM:      state_next = eci_pkg::ST_PROD;
      eci_pkg::ST_PROD: begin
        state_next = (zero_span || clamp) ? eci_pkg::ST_RESULT : eci_pkg::ST_DIV_GO;
      end
      eci_pkg::ST_DIV_GO:   state_next = eci_pkg::ST_DIV_WAIT;
      eci_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_next = eci_pkg::ST_RESULT;
        end
      end
      eci_pkg::ST_FALLBACK: state_next = eci_pkg::ST_RESULT;
      eci_pkg::ST_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = eci_pkg::ST_IDLE;
        end
      end
      default: state_next = eci_pkg::ST_IDLE;
    endcase
  end

  // read pointer pipeline: data_idx names the entry now on tbl_rdata
  always_ff @(posedge clk) begin
    if (rst) begin
      data_vld <= 1'b0;
    end else begin
      data_vld <= (state == eci_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    data_idx <= rd_ptr;
    if (conv_take) begin
      raw    <= raw_angle;
      n_last <= n_last_next;
      rd_ptr <= '0;
    end
    if (state == eci_pkg::ST_SCAN) begin
      if (rd_ptr != n_last) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (hit) begin
        k  <= data_idx;
        hi <= tbl_rdata;
      end else if (data_vld) begin
        lo <= tbl_rdata;
      end
    end
    if (state == eci_pkg::ST_NUM) begin
      num  <= num_next;
      span <= d2;
    end
    if (state == eci_pkg::ST_PROD) begin
      dividend <= DVD_W'(product) << (FRACTION_BITS - 4);
      divisor  <= span_abs[eci_pkg::RAW_W-1:0];
      if (zero_span || clamp) begin
        res_angle  <= '0;
        res_interp <= 1'b1;
        res_err    <= 1'b1;
      end
    end
    if (state == eci_pkg::ST_DIV_WAIT && div_res.done) begin
      res_angle  <= div_res.sat ? eci_pkg::ANGLE_MAX : div_res.quo;
      res_interp <= 1'b1;
      res_err    <= div_res.sat;
    end
    if (state == eci_pkg::ST_FALLBACK) begin
      res_angle  <= fb_sat ? eci_pkg::ANGLE_MAX : eci_pkg::ANGLE_W'(fb);
      res_interp <= 1'b0;
      res_err    <= fb_sat;
    end
  end

  // ------------------------------------------------------------------
  // response register
  // ------------------------------------------------------------------
  assign rsp_take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      angle        <= res_angle;
      interpolated <= res_interp;
      span_error   <= res_err;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    load_take |=> state == eci_pkg::ST_IDLE)
    else $error("load request left the idle state");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == eci_pkg::ST_DIV_WAIT)
    else $error("divider finished outside the wait state");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == eci_pkg::ST_RESULT)
    else $error("response raised without a finished convert");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && span_error |-> angle == '0 || angle == eci_pkg::ANGLE_MAX)
    else $error("span error flagged with an ordinary angle");
`endif

endmodule
`default_nettype wire

### rtl/eci_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eci_ram: generic single-write, single-read RAM
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module eci_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/eci_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eci_divider: saturating restoring divider
// one quotient bit per cycle; saturation found up front by comparing the
// dividend's upper part against the divisor
// ----------------------------------------------------------------------------
module eci_divider #(
  parameter int DVD_W = 39
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [DVD_W-1:0]             dividend,
  input  wire logic [eci_pkg::RAW_W-1:0]    divisor,
  output eci_pkg::div_result_t              result
);

  localparam int QW    = eci_pkg::ANGLE_W;
  localparam int HI_W  = DVD_W - QW;
  localparam int CMP_W = (HI_W > eci_pkg::RAW_W) ? HI_W : eci_pkg::RAW_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic                      busy;
  logic                      done;
  logic                      sat;
  logic [CNT_W-1:0]          cnt;
  logic [eci_pkg::RAW_W-1:0] dsr;
  logic [eci_pkg::RAW_W-1:0] rem;
  logic [QW-1:0]             quo;

  logic [HI_W-1:0]           hi;
  logic                      hi_ge;
  logic [eci_pkg::RAW_W:0]   trial;
  logic                      trial_ge;
  logic [eci_pkg::RAW_W:0]   trial_sub;

  assign hi        = dividend[DVD_W-1:QW];
  assign hi_ge     = CMP_W'(hi) >= CMP_W'(divisor);
  assign trial     = {rem, quo[QW-1]};
  assign trial_ge  = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dsr <= divisor;
        sat <= hi_ge;
        if (hi_ge) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(QW);
          rem  <= eci_pkg::RAW_W'(hi);
          quo  <= dividend[QW-1:0];
        end
      end else if (busy) begin
        rem <= trial_ge ? trial_sub[eci_pkg::RAW_W-1:0] : trial[eci_pkg::RAW_W-1:0];
        quo <= {quo[QW-2:0], trial_ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result.done = done;
  assign result.sat  = sat;
  assign result.quo  = quo;

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider reports done while still iterating");
`endif

endmodule
`default_nettype wire
